@@ rtl/core/e2u_pkg.sv @@
`default_nettype none

package e2u_pkg;

    // Stream widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    // Result field widths
    localparam int SEC_W  = 6;
    localparam int MIN_W  = 6;
    localparam int HOUR_W = 5;
    localparam int MDAY_W = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int WDAY_W = 3;
    localparam int PAD_W  = OUT_DATA_W - (SEC_W + MIN_W + HOUR_W + MDAY_W + MON_W
                                          + YEAR_W + WDAY_W);

    // Number of register stages in the datapath
    localparam int STAGES = 10;

    // Last representable moment, 9999-12-31 23:59:59, in seconds
    localparam logic [37:0] T_MAX = 38'd253402300799;

    // Pipeline control handed from the flow controller to the datapath
    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
    } e2u_flow_t;

endpackage

`default_nettype wire

@@ rtl/core/e2u_flow.sv @@
`default_nettype none

module e2u_flow (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output e2u_pkg::e2u_flow_t flow
);
    import e2u_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;

    // A stage takes a new item when it is empty or its item moves on
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    // Advance valid bits along with the data
    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = load[0];
    assign out_valid  = valid_reg[STAGES-1];
    assign flow.load  = load;
    assign flow.valid = valid_reg;

    // Items in flight change only by what enters and what leaves
    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) == $past($countones(valid_reg))
                 + (($past(in_valid) && $past(in_ready)) ? 1 : 0)
                 - (($past(out_valid) && $past(out_ready)) ? 1 : 0))
        else $error("item count in pipeline broken");

    // Any empty stage lets the input side move
    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> in_ready)
        else $error("input stalled with a free stage");

    // A full pipeline with a stalled output holds the input back
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !out_ready) |-> !in_ready)
        else $error("input taken into a full stalled pipeline");

endmodule

`default_nettype wire

@@ rtl/core/epoch_seconds_to_utc_date_core.sv @@
// Unix seconds to UTC calendar date and time, ten register stages.
// A result is shown on m_tvalid once its item has reached the last stage register.
// Throughput: one item per cycle unless m_tready stalls; each stage holds a short
// run of constant multiplies and adds, so the ten-stage register chain sets the
// latency. Reset clears only the stage valid bits; datapath registers are not reset.
`default_nettype none

module epoch_seconds_to_utc_date_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [e2u_pkg::IN_DATA_W-1:0]    s_tdata,  // [63:0] epoch_seconds
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
    // [21:17] day_of_month, [25:22] month_number, [39:26] calendar_year,
    // [42:40] day_of_week, [47:43] zero
    output logic [e2u_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import e2u_pkg::*;

    // Offset of a March-based month from 1 March: 367 * mon / 12 - 30
    function automatic logic [8:0] month_offset(input logic [3:0] mon);
        logic [8:0] off;
        case (mon)
            4'd1:    off = 9'd0;
            4'd2:    off = 9'd31;
            4'd3:    off = 9'd61;
            4'd4:    off = 9'd92;
            4'd5:    off = 9'd122;
            4'd6:    off = 9'd153;
            4'd7:    off = 9'd184;
            4'd8:    off = 9'd214;
            4'd9:    off = 9'd245;
            4'd10:   off = 9'd275;
            4'd11:   off = 9'd306;
            4'd12:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    e2u_flow_t         flow;
    logic [STAGES-1:0] take;

    e2u_flow u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .flow      (flow)
    );

    // Load a stage only when it moves and a real item arrives
    always_comb
    begin
        take[0] = flow.load[0] && s_tvalid;
        for (int i = 1; i < STAGES; i++)
        begin
            take[i] = flow.load[i] && flow.valid[i-1];
        end
    end

    // ---------------- stage 0: clamp ----------------
    logic [37:0] t_clamp;
    logic [30:0] s0_x_reg;
    logic [6:0]  s0_lo_reg;

    // Drop negatives to zero, saturate past the last supported second
    always_comb
    begin
        if (s_tdata[63])
        begin
            t_clamp = '0;
        end
        else if ((|s_tdata[62:38]) || (s_tdata[37:0] > T_MAX))
        begin
            t_clamp = T_MAX;
        end
        else
        begin
            t_clamp = s_tdata[37:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            s0_x_reg  <= t_clamp[37:7];
            s0_lo_reg <= t_clamp[6:0];
        end
    end

    // ---------------- stage 1: day quotient ----------------
    // seconds / 86400 = (seconds >> 7) / 675, by reciprocal 2^41 / 675
    logic [62:0] day_prod;
    logic [21:0] s1_q_reg;
    logic [30:0] s1_x_reg;
    logic [6:0]  s1_lo_reg;

    assign day_prod = {32'd0, s0_x_reg} * {31'd0, 32'd3257812231};

    always_ff @(posedge clk)
    begin
        if (take[1])
        begin
            s1_q_reg  <= day_prod[62:41];
            s1_x_reg  <= s0_x_reg;
            s1_lo_reg <= s0_lo_reg;
        end
    end

    // ---------------- stage 2: second of day ----------------
    logic [31:0] q_scaled;
    logic [30:0] x_rem;
    logic [21:0] s2_day_reg;
    logic [16:0] s2_sod_reg;

    assign q_scaled = {10'd0, s1_q_reg} * 32'd675;
    assign x_rem    = s1_x_reg - q_scaled[30:0];

    always_ff @(posedge clk)
    begin
        if (take[2])
        begin
            s2_day_reg <= s1_q_reg;
            s2_sod_reg <= {x_rem[9:0], s1_lo_reg};
        end
    end

    // ---------------- stage 3: era shift, hour and weekday quotients ----------------
    logic [30:0] era_num;
    logic [34:0] hour_prod;
    logic [21:0] wday_base;
    logic [44:0] wday_prod;
    logic [21:0] s3_days2_reg;
    logic [30:0] s3_n_reg;
    logic [4:0]  s3_hour_reg;
    logic [16:0] s3_sod_reg;
    logic [19:0] s3_wq_reg;
    logic [21:0] s3_v7_reg;

    // Day count from 1 March of year 0, plus two, times 400
    assign era_num   = ({9'd0, s2_day_reg} + 31'd719470) * 31'd400;
    assign hour_prod = {18'd0, s2_sod_reg} * {17'd0, 18'd149131};
    assign wday_base = s2_day_reg + 22'd4;
    assign wday_prod = {23'd0, wday_base} * {22'd0, 23'd4793491};

    always_ff @(posedge clk)
    begin
        if (take[3])
        begin
            s3_days2_reg <= s2_day_reg + 22'd719468;
            s3_n_reg     <= era_num;
            s3_hour_reg  <= hour_prod[33:29];
            s3_sod_reg   <= s2_sod_reg;
            s3_wq_reg    <= wday_prod[44:25];
            s3_v7_reg    <= wday_base;
        end
    end

    // ---------------- stage 4: year estimate, remainders ----------------
    logic [61:0] year_prod;
    logic [16:0] hour_scaled;
    logic [16:0] sod_left;
    logic [21:0] wq_scaled;
    logic [21:0] wday_left;
    logic [21:0] s4_days2_reg;
    logic [13:0] s4_year_reg;
    logic [4:0]  s4_hour_reg;
    logic [11:0] s4_srem_reg;
    logic [2:0]  s4_wday_reg;

    // Year estimate from the 146097-day cycle, reciprocal 2^48 / 146097
    assign year_prod   = {31'd0, s3_n_reg} * {31'd0, 31'd1926630778};
    assign hour_scaled = {12'd0, s3_hour_reg} * 17'd3600;
    assign sod_left    = s3_sod_reg - hour_scaled;
    assign wq_scaled   = {2'd0, s3_wq_reg} * 22'd7;
    assign wday_left   = s3_v7_reg - wq_scaled;

    always_ff @(posedge clk)
    begin
        if (take[4])
        begin
            s4_days2_reg <= s3_days2_reg;
            s4_year_reg  <= year_prod[61:48];
            s4_hour_reg  <= s3_hour_reg;
            s4_srem_reg  <= sod_left[11:0];
            s4_wday_reg  <= wday_left[2:0];
        end
    end

    // ---------------- stage 5: century and minute quotients ----------------
    logic [27:0] cent_prod;
    logic [24:0] min_prod;
    logic [21:0] s5_days2_reg;
    logic [13:0] s5_year_reg;
    logic [6:0]  s5_cent_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_srem_reg;
    logic [5:0]  s5_min_reg;
    logic [2:0]  s5_wday_reg;

    assign cent_prod = {14'd0, s4_year_reg} * {14'd0, 14'd10486};
    assign min_prod  = {13'd0, s4_srem_reg} * {12'd0, 13'd4370};

    always_ff @(posedge clk)
    begin
        if (take[5])
        begin
            s5_days2_reg <= s4_days2_reg;
            s5_year_reg  <= s4_year_reg;
            s5_cent_reg  <= cent_prod[26:20];
            s5_hour_reg  <= s4_hour_reg;
            s5_srem_reg  <= s4_srem_reg;
            s5_min_reg   <= min_prod[23:18];
            s5_wday_reg  <= s4_wday_reg;
        end
    end

    // ---------------- stage 6: day within year, leap flag ----------------
    logic [21:0]        year_days;
    logic signed [23:0] yday_raw;
    logic [13:0]        cent_scaled;
    logic [13:0]        year_mod100;
    logic               leap;
    logic [11:0]        min_scaled;
    logic [11:0]        sec_left;
    logic signed [23:0] s6_yday_reg;
    logic               s6_leap_reg;
    logic [13:0]        s6_year_reg;
    logic [4:0]         s6_hour_reg;
    logic [5:0]         s6_min_reg;
    logic [5:0]         s6_sec_reg;
    logic [2:0]         s6_wday_reg;

    // Days before 1 March of the estimated year
    assign year_days = {8'd0, s5_year_reg} * 22'd365
                     + {10'd0, s5_year_reg[13:2]}
                     - {15'd0, s5_cent_reg}
                     + {17'd0, s5_cent_reg[6:2]};
    assign yday_raw    = $signed({2'b00, s5_days2_reg}) - $signed({2'b00, year_days});
    assign cent_scaled = {7'd0, s5_cent_reg} * 14'd100;
    assign year_mod100 = s5_year_reg - cent_scaled;
    assign leap        = (s5_year_reg[1:0] == 2'd0)
                      && ((year_mod100 != 14'd0) || (s5_cent_reg[1:0] == 2'd0));
    assign min_scaled  = {6'd0, s5_min_reg} * 12'd60;
    assign sec_left    = s5_srem_reg - min_scaled;

    always_ff @(posedge clk)
    begin
        if (take[6])
        begin
            s6_yday_reg <= yday_raw;
            s6_leap_reg <= leap;
            s6_year_reg <= s5_year_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_min_reg  <= s5_min_reg;
            s6_sec_reg  <= sec_left[5:0];
            s6_wday_reg <= s5_wday_reg;
        end
    end

    // ---------------- stage 7: correct an overshooting year ----------------
    logic [23:0] yday_fixed;
    logic [8:0]  yday_sel;
    logic [13:0] year_sel;
    logic [8:0]  s7_yday_reg;
    logic [13:0] s7_year_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;
    logic [5:0]  s7_sec_reg;
    logic [2:0]  s7_wday_reg;

    assign yday_fixed = s6_yday_reg + 24'd365 + {23'd0, s6_leap_reg};

    // Step back one year when the day count fell before its start
    always_comb
    begin
        if (s6_yday_reg[23])
        begin
            yday_sel = yday_fixed[8:0];
            year_sel = s6_year_reg - 14'd1;
        end
        else
        begin
            yday_sel = s6_yday_reg[8:0];
            year_sel = s6_year_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[7])
        begin
            s7_yday_reg <= yday_sel;
            s7_year_reg <= year_sel;
            s7_hour_reg <= s6_hour_reg;
            s7_min_reg  <= s6_min_reg;
            s7_sec_reg  <= s6_sec_reg;
            s7_wday_reg <= s6_wday_reg;
        end
    end

    // ---------------- stage 8: month from day within year ----------------
    // (yday + 31) * 10 / 306, by reciprocal 2^21 / 306
    logic [11:0] mon_num;
    logic [24:0] mon_prod;
    logic [8:0]  s8_yday_reg;
    logic [3:0]  s8_mon_reg;
    logic [13:0] s8_year_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg;
    logic [5:0]  s8_sec_reg;
    logic [2:0]  s8_wday_reg;

    assign mon_num  = ({3'd0, s7_yday_reg} + 12'd31) * 12'd10;
    assign mon_prod = {13'd0, mon_num} * {12'd0, 13'd6854};

    always_ff @(posedge clk)
    begin
        if (take[8])
        begin
            s8_yday_reg <= s7_yday_reg;
            s8_mon_reg  <= mon_prod[24:21];
            s8_year_reg <= s7_year_reg;
            s8_hour_reg <= s7_hour_reg;
            s8_min_reg  <= s7_min_reg;
            s8_sec_reg  <= s7_sec_reg;
            s8_wday_reg <= s7_wday_reg;
        end
    end

    // ---------------- stage 9: day of month, January-based month ----------------
    logic [8:0]  mday_full;
    logic [3:0]  mon_adj;
    logic [13:0] year_adj;
    logic [SEC_W-1:0]  s9_sec_reg;
    logic [MIN_W-1:0]  s9_min_reg;
    logic [HOUR_W-1:0] s9_hour_reg;
    logic [MDAY_W-1:0] s9_mday_reg;
    logic [MON_W-1:0]  s9_mon_reg;
    logic [YEAR_W-1:0] s9_year_reg;
    logic [WDAY_W-1:0] s9_wday_reg;

    assign mday_full = s8_yday_reg - month_offset(s8_mon_reg) + 9'd1;

    // January and February belong to the next calendar year
    always_comb
    begin
        if (s8_yday_reg >= 9'd306)
        begin
            mon_adj  = s8_mon_reg - 4'd10;
            year_adj = s8_year_reg + 14'd1;
        end
        else
        begin
            mon_adj  = s8_mon_reg + 4'd2;
            year_adj = s8_year_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[9])
        begin
            s9_sec_reg  <= s8_sec_reg;
            s9_min_reg  <= s8_min_reg;
            s9_hour_reg <= s8_hour_reg;
            s9_mday_reg <= mday_full[4:0];
            s9_mon_reg  <= mon_adj;
            s9_year_reg <= year_adj;
            s9_wday_reg <= s8_wday_reg;
        end
    end

    assign m_tdata = {{PAD_W{1'b0}}, s9_wday_reg, s9_year_reg, s9_mon_reg,
                      s9_mday_reg, s9_hour_reg, s9_min_reg, s9_sec_reg};

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import e2u_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = STAGES + 16;

    localparam longint unsigned SECS_PER_DAY   = 64'd86400;
    localparam longint unsigned LAST_DAY_NUM   = 64'd2932896;
    localparam longint unsigned LAST_DAY_SEC   = 64'd86399;
    localparam longint          DAYS_TO_MARCH0 = 64'd719468;
    localparam longint          DAYS_PER_ERA   = 64'd146097;
    localparam longint unsigned LAST_MOMENT    = 64'(T_MAX);

    localparam int FIELDS_W = OUT_DATA_W - PAD_W;

    // Result fields, weekday in the top bits, second in the lowest
    typedef struct packed {
        logic [WDAY_W-1:0] wday;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  mon;
        logic [MDAY_W-1:0] mday;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  min;
        logic [SEC_W-1:0]  sec;
    } utc_date_t;

    typedef enum logic [1:0] {
        PACE_OPEN,
        PACE_LIGHT,
        PACE_HEAVY,
        PACE_PERIODIC
    } rx_pace_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // [63:0] epoch_seconds
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day of month,
    // [25:22] month, [39:26] year, [42:40] weekday, [47:43] zero
    logic [OUT_DATA_W-1:0] m_tdata;

    utc_date_t expected_dates[$];
    int        errors        = 0;
    int        items_sent    = 0;
    int        dates_checked = 0;
    int        clamped_cnt   = 0;
    int        saturated_cnt = 0;
    int        burst_left    = 0;
    int        quiet_cycles  = 0;
    int        rx_left       = 0;
    int        rx_tick       = 0;
    rx_pace_t  rx_pace       = PACE_OPEN;

    epoch_seconds_to_utc_date_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // Compute the UTC date and time of a signed seconds count
    function automatic utc_date_t civil_from_epoch(input logic [63:0] raw);
        longint unsigned secs;
        longint unsigned day_num;
        longint unsigned sec_of_day;
        longint          march_days;
        longint          yr;
        longint          doy;
        longint          mo;
        longint          dm;
        longint          leap;
        utc_date_t       r;
        // clamp negatives to the epoch, saturate past the last day
        secs       = raw[63] ? 64'd0 : raw;
        day_num    = secs / SECS_PER_DAY;
        sec_of_day = secs % SECS_PER_DAY;
        if (day_num > LAST_DAY_NUM)
        begin
            day_num    = LAST_DAY_NUM;
            sec_of_day = LAST_DAY_SEC;
        end
        r.wday = WDAY_W'((day_num + 64'd4) % 64'd7);
        r.hour = HOUR_W'(sec_of_day / 64'd3600);
        r.min  = MIN_W'((sec_of_day % 64'd3600) / 64'd60);
        r.sec  = SEC_W'(sec_of_day % 64'd60);

        // estimate the March-based year, then step back on overshoot
        march_days = longint'(day_num) + DAYS_TO_MARCH0;
        yr  = (march_days + 2) * 400 / DAYS_PER_ERA;
        doy = march_days - (365 * yr + yr / 4 - yr / 100 + yr / 400);
        if (doy < 0)
        begin
            leap = ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 1 : 0;
            doy  = doy + 365 + leap;
            yr   = yr - 1;
        end

        // month and day within the March-based year
        mo = (doy + 31) * 10 / 306;
        dm = doy - (367 * mo / 12 - 30) + 1;
        if (doy >= 306)
        begin
            yr = yr + 1;
            mo = mo - 10;
        end
        else
        begin
            mo = mo + 2;
        end
        r.mday = MDAY_W'(dm);
        r.mon  = MON_W'(mo);
        r.year = YEAR_W'(yr);
        return r;
    endfunction

    // Offer one item, honoring the burst and gap pattern of the sender
    task automatic send_seconds(input logic [63:0] secs);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 60)
                                                      : $urandom_range(16, 1);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do @(posedge clk); while (!s_tready);
        expected_dates.push_back(civil_from_epoch(secs));
        burst_left--;
        items_sent++;
        if (secs[63])
            clamped_cnt++;
        else if (secs > LAST_MOMENT)
            saturated_cnt++;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Corners: field extremes, time-of-day rollovers, leap and non-leap
    // February ends, the clamp below zero and the saturation past 9999
    task automatic test_directed();
        logic [63:0] corner_secs[$] = '{
            64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h7FFF_FFFF_FFFF_FFFF, 64'd59, 64'd60, 64'd3599, 64'd3600,
            64'd86399, 64'd86400, 64'hFFFF_FFFF_FFFE_AE80,
            64'd946684799, 64'd946684800, 64'd951782399, 64'd951782400,
            64'd951868800, 64'd4107542399, 64'd4107542400,
            64'd2147483648, 64'd4294967295,
            LAST_MOMENT - 64'd86399, LAST_MOMENT, LAST_MOMENT + 64'd1,
            LAST_MOMENT + 64'd86400
        };
        foreach (corner_secs[i])
            send_seconds(corner_secs[i]);
    endtask

    // Uniform over the whole valid span, half of it within the 32-bit era
    task automatic test_uniform_range(input int n);
        logic [63:0] secs;
        repeat (n)
        begin
            secs = {$urandom, $urandom};
            if ($urandom_range(1, 0) == 0)
                secs = secs % (LAST_MOMENT + 64'd1);
            else
                secs = {32'd0, secs[31:0]};
            send_seconds(secs);
        end
    endtask

    // Random days, times of day at or near the hour and day rollovers
    task automatic test_day_boundaries(input int n);
        longint unsigned day_num;
        longint unsigned sod;
        repeat (n)
        begin
            day_num = $urandom_range(LAST_DAY_NUM, 0);
            case ($urandom_range(7, 0))
                0:       sod = 0;
                1:       sod = 59;
                2:       sod = 60;
                3:       sod = 3599;
                4:       sod = 3600;
                5:       sod = 43200;
                6:       sod = LAST_DAY_SEC;
                default: sod = $urandom_range(LAST_DAY_SEC, 0);
            endcase
            send_seconds(day_num * SECS_PER_DAY + sod);
        end
    endtask

    // Negative inputs, the last valid day and everything past it
    task automatic test_clamp_and_saturate(input int n);
        logic [63:0] secs;
        repeat (n)
        begin
            secs = {$urandom, $urandom};
            case ($urandom_range(4, 0))
                0:       secs[63] = 1'b1;
                1:       secs = -64'($urandom_range(1000000, 1));
                2:       secs = LAST_MOMENT + 64'($urandom_range(200000, 1));
                3:       secs[63] = 1'b0;
                default: secs = LAST_MOMENT - 64'($urandom_range(86399, 0));
            endcase
            send_seconds(secs);
        end
    endtask

    // Walk a single one and a single zero through every input bit
    task automatic test_single_bits();
        for (int b = 0; b < IN_DATA_W; b++)
        begin
            send_seconds(64'd1 << b);
            send_seconds(~(64'd1 << b));
        end
    endtask

    task automatic test_raw_patterns(input int n);
        repeat (n)
            send_seconds({$urandom, $urandom});
    endtask

    // Check each result item against the oldest expected date
    always @(posedge clk)
    begin : check_dates
        utc_date_t got;
        utc_date_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[FIELDS_W-1:0];
            if (expected_dates.size() == 0)
            begin
                $error("result item with no pending input: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                dates_checked++;
                check_field("second_of_minute", want.sec, got.sec);
                check_field("minute_of_hour", want.min, got.min);
                check_field("hour_of_day", want.hour, got.hour);
                check_field("day_of_month", want.mday, got.mday);
                check_field("month_number", want.mon, got.mon);
                check_field("calendar_year", want.year, got.year);
                check_field("day_of_week", want.wday, got.wday);
                check_field("padding", 0, m_tdata[OUT_DATA_W-1:FIELDS_W]);
            end
        end
    end

    // Pace the receiver: phases of open flow, light and heavy stalls, a fixed rhythm
    always @(posedge clk)
    begin : pace_receiver
        if (rx_left == 0)
        begin
            rx_pace = rx_pace_t'($urandom_range(3, 0));
            rx_left = $urandom_range(200, 20);
        end
        rx_left--;
        rx_tick++;
        case (rx_pace)
            PACE_OPEN:     m_tready <= 1'b1;
            PACE_LIGHT:    m_tready <= ($urandom_range(3, 0) != 0);
            PACE_HEAVY:    m_tready <= ($urandom_range(3, 0) == 0);
            PACE_PERIODIC: m_tready <= (rx_tick % 5 == 0);
            default:       m_tready <= 1'b1;
        endcase
    end

    // Abort when neither side has moved an item for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("epoch_seconds_to_utc_date_core test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_uniform_range(600);
        test_day_boundaries(500);
        test_clamp_and_saturate(250);
        test_single_bits();
        test_raw_patterns(200);
        s_tvalid <= 1'b0;

        // drain the pipeline, then watch for stray results
        while (expected_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d timestamps, compared %0d dates", items_sent, dates_checked);
        $display("%0d clamped below the epoch, %0d saturated past year 9999",
                 clamped_cnt, saturated_cnt);
        if (errors == 0)
            $display("epoch_seconds_to_utc_date_core test passed");
        else
            $display("epoch_seconds_to_utc_date_core test failed");
        $finish;
    end

endmodule
